// ----- hdl/ntcn_pkg.sv -----
// Shared constants and codes for the neighbor table with common-neighbor queries.
package ntcn_pkg;

  localparam int NODE_W   = 6;
  localparam int STATUS_W = 3;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 16;
  localparam int RANGE_W  = 13;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LINKED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SAME   = 3'd4;

endpackage

// ----- hdl/neighbor_table_common_neighbors_top.sv -----
// Neighbor table top level: bounded neighbor lists with add and common-neighbor query.
// Add: reads both list lengths, walks the first node's list for the second node, then writes both lists.
// Query: marks the first node's list, scans the second's, clears marks; one request in work at a time.
// Sequential walks over the list memory set the timing.
// Reset: a clearing pass zeroes the count and mark memories;
// no request is taken during it.
module neighbor_table_common_neighbors_top #(
  parameter int NODE_COUNT = 64,
  parameter int LIST_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ntcn_pkg::S_DATA_W-1:0] s_axis_tdata,  // node_first, node_second, zero pad
  input  logic                         s_axis_tuser,  // cmd
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [ntcn_pkg::M_DATA_W-1:0] m_axis_tdata,  // status, common_node, zero pad
  output logic                         m_axis_tuser,  // has_value
  output logic                         m_axis_tlast
);

  localparam int NW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int SW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW  = $clog2(LIST_DEPTH + 1);
  localparam int LAW = NW + SW;
  localparam int LDEPTH = NODE_COUNT << SW;
  localparam int IDW = ntcn_pkg::NODE_W;
  localparam int STW = ntcn_pkg::STATUS_W;
  localparam int PADW = ntcn_pkg::M_DATA_W - IDW - STW;
  localparam logic [ntcn_pkg::RANGE_W-1:0] NC_LIM = ntcn_pkg::RANGE_W'(NODE_COUNT);
  localparam logic [CW-1:0] LD_C = CW'(LIST_DEPTH);
  localparam logic [NW-1:0] LAST_NODE = NW'(NODE_COUNT - 1);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CNTA   = 4'd2;
  localparam logic [3:0] S_CNTB   = 4'd3;
  localparam logic [3:0] S_LNK    = 4'd4;
  localparam logic [3:0] S_WR1    = 4'd5;
  localparam logic [3:0] S_WR2    = 4'd6;
  localparam logic [3:0] S_MARK   = 4'd7;
  localparam logic [3:0] S_SCAN   = 4'd8;
  localparam logic [3:0] S_SCAN_M = 4'd9;
  localparam logic [3:0] S_SCAN_C = 4'd10;
  localparam logic [3:0] S_UNMARK = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;

  logic [3:0]     state;
  logic [NW-1:0]  clr_idx;
  logic           cmd_q;
  logic [IDW-1:0] a_id;
  logic [IDW-1:0] b_id;
  logic [CW-1:0]  cnt_a;
  logic [CW-1:0]  cnt_b;
  logic [CW-1:0]  walk_idx;
  logic           rd_vld;
  logic           found;
  logic [IDW-1:0] scan_v;
  logic [IDW-1:0] pend;
  logic           pend_vld;
  logic [STW-1:0] res_status;
  logic [STW-1:0] out_status;
  logic [IDW-1:0] out_node;

  logic [IDW-1:0] in_first;
  logic [IDW-1:0] in_second;
  logic           in_bad;
  logic           accept;
  logic           out_free;
  logic [NW-1:0]  a_node;
  logic [NW-1:0]  b_node;
  logic [CW-1:0]  walk_cnt;
  logic           walk_issue;
  logic           walk_done;
  logic           hit;

  logic           list_we;
  logic [LAW-1:0] list_waddr;
  logic [IDW-1:0] list_wdata;
  logic [LAW-1:0] list_raddr;
  logic [IDW-1:0] list_rdata;

  logic           count_we;
  logic [NW-1:0]  count_waddr;
  logic [CW-1:0]  count_wdata;
  logic [NW-1:0]  count_raddr;
  logic [CW-1:0]  count_rdata;

  logic           mark_we;
  logic [NW-1:0]  mark_waddr;
  logic [0:0]     mark_wdata;
  logic [NW-1:0]  mark_raddr;
  logic [0:0]     mark_rdata;

  assign in_first  = s_axis_tdata[IDW-1:0];
  assign in_second = s_axis_tdata[2*IDW-1:IDW];
  assign in_bad    = (ntcn_pkg::RANGE_W'(in_first) >= NC_LIM) ||
                     (ntcn_pkg::RANGE_W'(in_second) >= NC_LIM);
  assign s_axis_tready = (state == S_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign m_axis_tdata = {{PADW{1'b0}}, out_node, out_status};

  always_comb begin
    a_node     = NW'(a_id);
    b_node     = NW'(b_id);
    walk_cnt   = (state == S_SCAN) ? cnt_b : cnt_a;
    walk_issue = walk_idx < walk_cnt;
    walk_done  = !walk_issue && !rd_vld;
    hit        = mark_rdata[0] && (scan_v != a_id);

    list_raddr = {((state == S_SCAN) ? b_node : a_node), walk_idx[SW-1:0]};
    list_we    = (state == S_WR1) || (state == S_WR2);
    list_waddr = (state == S_WR1) ? {a_node, cnt_a[SW-1:0]} : {b_node, cnt_b[SW-1:0]};
    list_wdata = (state == S_WR1) ? b_id : a_id;

    count_raddr = (state == S_IDLE) ? NW'(in_first) : b_node;
    count_we    = (state == S_CLR) || (state == S_WR1) || (state == S_WR2);
    if (state == S_CLR) begin
      count_waddr = clr_idx;
      count_wdata = '0;
    end else if (state == S_WR1) begin
      count_waddr = a_node;
      count_wdata = cnt_a + CW'(1);
    end else begin
      count_waddr = b_node;
      count_wdata = cnt_b + CW'(1);
    end

    mark_raddr = (state == S_SCAN_M) ? NW'(list_rdata) : NW'(scan_v);
    mark_we    = (state == S_CLR) ||
                 (((state == S_MARK) || (state == S_UNMARK)) && rd_vld);
    mark_waddr = (state == S_CLR) ? clr_idx : NW'(list_rdata);
    mark_wdata = (state == S_MARK) ? 1'b1 : 1'b0;
  end

  ntcn_ram #(.WIDTH(IDW), .DEPTH(LDEPTH)) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  ntcn_ram #(.WIDTH(CW), .DEPTH(NODE_COUNT)) u_count_ram (
    .clk   (clk),
    .we    (count_we),
    .waddr (count_waddr),
    .wdata (count_wdata),
    .raddr (count_raddr),
    .rdata (count_rdata)
  );

  ntcn_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (mark_raddr),
    .rdata (mark_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_idx       <= '0;
      walk_idx      <= '0;
      rd_vld        <= 1'b0;
      pend_vld      <= 1'b0;
      found         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + NW'(1);
          if (clr_idx == LAST_NODE) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_q      <= s_axis_tuser;
            a_id       <= in_first;
            b_id       <= in_second;
            pend_vld   <= 1'b0;
            found      <= 1'b0;
            res_status <= ntcn_pkg::ST_OK;
            if (in_bad) begin
              res_status <= ntcn_pkg::ST_RANGE;
              state      <= S_FIN;
            end else if ((s_axis_tuser == ntcn_pkg::CMD_ADD) && (in_first == in_second)) begin
              res_status <= ntcn_pkg::ST_SAME;
              state      <= S_FIN;
            end else begin
              state <= S_CNTA;
            end
          end
        end
        S_CNTA: begin
          cnt_a <= count_rdata;
          state <= S_CNTB;
        end
        S_CNTB: begin
          cnt_b    <= count_rdata;
          walk_idx <= '0;
          rd_vld   <= 1'b0;
          if (cmd_q == ntcn_pkg::CMD_ADD) begin
            if ((cnt_a == LD_C) || (count_rdata == LD_C)) begin
              res_status <= ntcn_pkg::ST_FULL;
              state      <= S_FIN;
            end else begin
              state <= S_LNK;
            end
          end else begin
            state <= S_MARK;
          end
        end
        S_LNK, S_MARK, S_UNMARK: begin
          if (walk_issue) begin
            walk_idx <= walk_idx + CW'(1);
          end
          rd_vld <= walk_issue;
          if ((state == S_LNK) && rd_vld && (list_rdata == b_id)) begin
            found <= 1'b1;
          end
          if (walk_done) begin
            walk_idx <= '0;
            priority if (state == S_LNK) begin
              if (found) begin
                res_status <= ntcn_pkg::ST_LINKED;
                state      <= S_FIN;
              end else begin
                state <= S_WR1;
              end
            end else if (state == S_MARK) begin
              state <= S_SCAN;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_WR1: begin
          state <= S_WR2;
        end
        S_WR2: begin
          state <= S_FIN;
        end
        S_SCAN: begin
          if (walk_issue) begin
            walk_idx <= walk_idx + CW'(1);
            state    <= S_SCAN_M;
          end else begin
            walk_idx <= '0;
            rd_vld   <= 1'b0;
            state    <= S_UNMARK;
          end
        end
        S_SCAN_M: begin
          scan_v <= list_rdata;
          state  <= S_SCAN_C;
        end
        S_SCAN_C: begin
          if (!(hit && pend_vld && !out_free)) begin
            if (hit && pend_vld) begin
              m_axis_tvalid <= 1'b1;
              out_status    <= ntcn_pkg::ST_OK;
              out_node      <= pend;
              m_axis_tuser  <= 1'b1;
              m_axis_tlast  <= 1'b0;
            end
            if (hit) begin
              pend     <= scan_v;
              pend_vld <= 1'b1;
            end
            state <= S_SCAN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            out_status    <= res_status;
            out_node      <= pend_vld ? pend : '0;
            m_axis_tuser  <= pend_vld;
            m_axis_tlast  <= 1'b1;
            pend_vld      <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_vld)
    else $error("pending result left over in idle");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count_we |-> (count_wdata <= LD_C))
    else $error("neighbor count written beyond list depth");

  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    ((state == S_LNK) || (state == S_MARK) || (state == S_UNMARK) || (state == S_SCAN))
      |-> (walk_idx <= walk_cnt))
    else $error("list walk ran past the list length");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted request did not start work");

endmodule

// ----- hdl/ntcn_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module ntcn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
